// File: hw/rtl/dtv_pkg.sv
package dtv_pkg;

    // Format modes held in the mode register.
    localparam logic [2:0] MODE_HMS      = 3'd0;
    localparam logic [2:0] MODE_MMDD     = 3'd1;
    localparam logic [2:0] MODE_YMD      = 3'd2;
    localparam logic [2:0] MODE_WDAY     = 3'd3;
    localparam logic [2:0] MODE_WDAY_HMS = 3'd4;
    localparam logic [2:0] MODE_MMDD_HMS = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_FORMAT_MODE  = 1'b0;
    localparam logic CFG_CURRENT_YEAR = 1'b1;

    // Status codes.
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_HMS_LEN  = 4'd1;
    localparam logic [3:0] ST_MMDD_LEN = 4'd2;
    localparam logic [3:0] ST_YMD_LEN  = 4'd3;
    localparam logic [3:0] ST_DIGIT    = 4'd4;
    localparam logic [3:0] ST_HOURS    = 4'd5;
    localparam logic [3:0] ST_MINUTES  = 4'd6;
    localparam logic [3:0] ST_SECONDS  = 4'd7;
    localparam logic [3:0] ST_MONTH    = 4'd8;
    localparam logic [3:0] ST_DAY      = 4'd9;
    localparam logic [3:0] ST_COLON    = 4'd11;
    localparam logic [3:0] ST_DASH     = 4'd12;
    localparam logic [3:0] ST_SPACE    = 4'd13;
    localparam logic [3:0] ST_WEEKDAY  = 4'd14;
    localparam logic [3:0] ST_INVALID  = 4'd15;

    localparam int unsigned NUM_NAMES  = 14;
    localparam logic [NUM_NAMES-1:0] NAME_ALL = '1;

    // Weekday names, right-justified in 9 character slots.
    localparam logic [71:0] DAY_NAMES [NUM_NAMES] = '{
        72'("Mon"), 72'("Monday"), 72'("Tue"), 72'("Tuesday"),
        72'("Wed"), 72'("Wednesday"), 72'("Thu"), 72'("Thursday"),
        72'("Fri"), 72'("Friday"), 72'("Sat"), 72'("Saturday"),
        72'("Sun"), 72'("Sunday")
    };
    localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
        4'd3, 4'd6, 4'd3, 4'd7, 4'd3, 4'd9, 4'd3,
        4'd8, 4'd3, 4'd6, 4'd3, 4'd8, 4'd3, 4'd6
    };

    // Days per month, indexed by month number; zero marks no valid month.
    localparam logic [4:0] MONTH_DAYS [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef enum logic [1:0] {
        KIND_HMS,
        KIND_MMDD,
        KIND_YMD,
        KIND_WDAY
    } t_kind;

    typedef struct packed {
        logic is_digit;
        logic is_space;
        logic is_colon;
        logic is_dash;
        logic is_day_tens;
    } t_cls;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        t_cls       cls;
    } t_item;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] year_lo;
    } t_cfg;

    // Character at position pos of weekday name idx; pos must be below its length.
    function automatic logic [7:0] day_char(input int unsigned idx, input logic [3:0] pos);
        logic [71:0] aligned;
        logic [7:0]  result;
        aligned = DAY_NAMES[idx] << (8 * (9 - int'(NAME_LEN[idx])));
        result  = 8'h00;
        for (int k = 0; k < 9; k++) begin
            if (pos == 4'(k)) begin
                result = aligned[71 - 8*k -: 8];
            end
        end
        return result;
    endfunction

    function automatic t_kind kind_of(input logic [2:0] mode, input logic tail);
        t_kind k;
        case (mode)
            MODE_HMS:      k = KIND_HMS;
            MODE_MMDD:     k = KIND_MMDD;
            MODE_YMD:      k = KIND_YMD;
            MODE_WDAY:     k = KIND_WDAY;
            MODE_WDAY_HMS: k = tail ? KIND_HMS : KIND_WDAY;
            default:       k = tail ? KIND_HMS : KIND_MMDD;
        endcase
        return k;
    endfunction

    // Judges a finished segment. len_hi flags a length of sixteen or more.
    function automatic logic [3:0] finish_kind(input t_kind k, input logic len_hi,
                                               input logic [3:0] len_lo,
                                               input logic [NUM_NAMES-1:0] mask,
                                               input logic [3:0] ferr);
        logic       found;
        logic [3:0] result;
        found = 1'b0;
        for (int unsigned i = 0; i < NUM_NAMES; i++) begin
            if (mask[i] && !len_hi && len_lo == NAME_LEN[i]) begin
                found = 1'b1;
            end
        end
        case (k)
            KIND_WDAY: result = found ? ST_OK : ST_WEEKDAY;
            KIND_HMS:  result = (!len_hi && len_lo == 4'd8)  ? ferr : ST_HMS_LEN;
            KIND_MMDD: result = (!len_hi && len_lo == 4'd5)  ? ferr : ST_MMDD_LEN;
            KIND_YMD:  result = (!len_hi && len_lo == 4'd10) ? ferr : ST_YMD_LEN;
            default:   result = ST_INVALID;
        endcase
        return result;
    endfunction

endpackage

// File: hw/rtl/dtv_front.sv
module dtv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] char_code
    input  logic          s_tlast,   // last_char
    output logic          o_q_valid,
    output dtv_pkg::t_item o_q_item,
    input  logic          i_q_pop
);
    import dtv_pkg::*;

    // Two-entry queue of classified characters.
    t_item      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       push;
    t_item      item_in;

    assign s_tready  = (r_count != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];

    always_comb begin
        item_in.ch              = s_tdata;
        item_in.last            = s_tlast;
        item_in.cls.is_digit    = (s_tdata >= "0") && (s_tdata <= "9");
        item_in.cls.is_space    = (s_tdata == " ");
        item_in.cls.is_colon    = (s_tdata == ":");
        item_in.cls.is_dash     = (s_tdata == "-");
        item_in.cls.is_day_tens = (s_tdata >= "0") && (s_tdata <= "3");
    end

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

endmodule

// File: hw/rtl/dtv_back.sv
module dtv_back #(
    parameter int COUNT_WIDTH = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dtv_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  dtv_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata    // [3:0] status, [7:4] zero
);
    import dtv_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_seg_pos,     n_seg_pos;
    logic                   r_space_seen,  n_space_seen;
    logic [3:0]             r_first_err,   n_first_err;
    logic                   r_err_latched, n_err_latched;
    logic [3:0]             r_tens,        n_tens;
    logic [3:0]             r_month,       n_month;
    logic                   r_leap,        n_leap;
    logic [NUM_NAMES-1:0]   r_mask,        n_mask;
    logic                   r_head_failed, n_head_failed;
    logic                   r_out_valid,   n_out_valid;
    logic [3:0]             r_status,      n_status;

    logic pop;

    // A last character may only proceed when the output slot is free or draining.
    assign pop      = i_q_valid && (!i_q_item.last || !r_out_valid || m_tready);
    assign o_q_pop  = pop;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0000, r_status};

    always_comb begin
        logic       compound;
        logic       p_hi;
        logic [3:0] p_lo;
        logic [3:0] dig;
        logic [6:0] val;
        logic [4:0] lim;
        logic [3:0] code;
        logic       hit;
        logic       seg_hi;
        t_kind      kind;

        n_seg_pos     = r_seg_pos;
        n_space_seen  = r_space_seen;
        n_first_err   = r_first_err;
        n_err_latched = r_err_latched;
        n_tens        = r_tens;
        n_month       = r_month;
        n_leap        = r_leap;
        n_mask        = r_mask;
        n_head_failed = r_head_failed;
        n_out_valid   = r_out_valid && !m_tready;
        n_status      = r_status;

        compound = (i_cfg.mode == MODE_WDAY_HMS) || (i_cfg.mode == MODE_MMDD_HMS);
        p_hi     = |(r_seg_pos >> 4);
        p_lo     = r_seg_pos[3:0];
        dig      = i_q_item.ch[3:0];
        val      = (7'(r_tens) << 3) + (7'(r_tens) << 1) + 7'(dig);
        lim      = MONTH_DAYS[r_month];
        code     = ST_OK;
        hit      = 1'b0;
        kind     = kind_of(i_cfg.mode, compound && r_space_seen);

        if (lim != 5'd0 && r_month == 4'd2 &&
            ((kind == KIND_MMDD) ? (i_cfg.year_lo == 2'b00) : r_leap)) begin
            lim = 5'd29;
        end

        if (pop && i_cfg.mode <= MODE_MMDD_HMS) begin
            if (compound && !r_space_seen && i_q_item.cls.is_space) begin
                // The first space closes the head segment and judges it.
                n_first_err   = finish_kind(kind, p_hi, p_lo, r_mask, r_first_err);
                n_space_seen  = 1'b1;
                n_seg_pos     = '0;
                n_head_failed = (n_first_err != ST_OK);
                n_err_latched = n_head_failed;
            end else if (!(compound && r_head_failed)) begin
                if (kind == KIND_WDAY) begin
                    for (int unsigned i = 0; i < NUM_NAMES; i++) begin
                        if (p_hi || p_lo >= NAME_LEN[i] ||
                            day_char(i, p_lo) != i_q_item.ch) begin
                            n_mask[i] = 1'b0;
                        end
                    end
                end else if (!r_err_latched && !p_hi) begin
                    case (kind)
                        KIND_HMS: begin
                            case (p_lo)
                                4'd0, 4'd3, 4'd6: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else begin
                                        n_tens = dig;
                                    end
                                end
                                4'd1, 4'd4, 4'd7: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else if (p_lo == 4'd1 && val > 7'd24) begin
                                        hit = 1'b1; code = ST_HOURS;
                                    end else if (p_lo == 4'd4 && val > 7'd59) begin
                                        hit = 1'b1; code = ST_MINUTES;
                                    end else if (p_lo == 4'd7 && val > 7'd59) begin
                                        hit = 1'b1; code = ST_SECONDS;
                                    end
                                end
                                4'd2, 4'd5: begin
                                    if (!i_q_item.cls.is_colon) begin
                                        hit = 1'b1; code = ST_COLON;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        KIND_MMDD: begin
                            case (p_lo)
                                4'd0: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else begin
                                        n_tens = dig;
                                    end
                                end
                                4'd1: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else if (val < 7'd1 || val > 7'd12) begin
                                        hit = 1'b1; code = ST_MONTH;
                                    end else begin
                                        n_month = val[3:0];
                                    end
                                end
                                4'd2: begin
                                    if (!i_q_item.cls.is_dash) begin
                                        hit = 1'b1; code = ST_DASH;
                                    end
                                end
                                4'd3: begin
                                    if (!i_q_item.cls.is_day_tens) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else begin
                                        n_tens = dig;
                                    end
                                end
                                4'd4: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else if (lim == 5'd0) begin
                                        hit = 1'b1; code = ST_INVALID;
                                    end else if (val < 7'd1 || val > 7'(lim)) begin
                                        hit = 1'b1; code = ST_DAY;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: begin
                            case (p_lo)
                                4'd0, 4'd1: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end
                                end
                                4'd2, 4'd5, 4'd8: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else begin
                                        n_tens = dig;
                                    end
                                end
                                4'd3: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else begin
                                        n_leap = (val[1:0] == 2'b00);
                                    end
                                end
                                4'd4, 4'd7: begin
                                    if (!i_q_item.cls.is_dash) begin
                                        hit = 1'b1; code = ST_DASH;
                                    end
                                end
                                4'd6: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else if (val < 7'd1 || val > 7'd12) begin
                                        hit = 1'b1; code = ST_MONTH;
                                    end else begin
                                        n_month = val[3:0];
                                    end
                                end
                                4'd9: begin
                                    if (!i_q_item.cls.is_digit) begin
                                        hit = 1'b1; code = ST_DIGIT;
                                    end else if (lim == 5'd0) begin
                                        hit = 1'b1; code = ST_INVALID;
                                    end else if (val < 7'd1 || val > 7'(lim)) begin
                                        hit = 1'b1; code = ST_DAY;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    endcase
                    if (hit) begin
                        n_first_err   = code;
                        n_err_latched = 1'b1;
                    end
                end
                if (r_seg_pos != CNT_MAX) begin
                    n_seg_pos = r_seg_pos + COUNT_WIDTH'(1);
                end
            end
        end

        if (pop && i_q_item.last) begin
            seg_hi = |(n_seg_pos >> 4);
            if (i_cfg.mode > MODE_MMDD_HMS) begin
                n_status = ST_INVALID;
            end else if (compound && !n_space_seen) begin
                n_status = ST_SPACE;
            end else if (compound && n_head_failed) begin
                n_status = n_first_err;
            end else begin
                n_status = finish_kind(kind_of(i_cfg.mode, compound), seg_hi,
                                       n_seg_pos[3:0], n_mask, n_first_err);
            end
            n_out_valid   = 1'b1;
            n_seg_pos     = '0;
            n_space_seen  = 1'b0;
            n_first_err   = ST_OK;
            n_err_latched = 1'b0;
            n_tens        = 4'd0;
            n_month       = 4'd0;
            n_leap        = 1'b0;
            n_mask        = NAME_ALL;
            n_head_failed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_pos     <= '0;
            r_space_seen  <= 1'b0;
            r_first_err   <= ST_OK;
            r_err_latched <= 1'b0;
            r_tens        <= 4'd0;
            r_month       <= 4'd0;
            r_leap        <= 1'b0;
            r_mask        <= NAME_ALL;
            r_head_failed <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_seg_pos     <= n_seg_pos;
            r_space_seen  <= n_space_seen;
            r_first_err   <= n_first_err;
            r_err_latched <= n_err_latched;
            r_tens        <= n_tens;
            r_month       <= n_month;
            r_leap        <= n_leap;
            r_mask        <= n_mask;
            r_head_failed <= n_head_failed;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    a_last_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_q_item.last) |-> (!r_out_valid || m_tready))
        else $error("last character consumed while a status was still held");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_q_item.last) |=> (r_seg_pos == '0 && !r_space_seen && !r_err_latched))
        else $error("string state not cleared after the last character");

    a_head_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_failed |-> r_space_seen)
        else $error("head segment marked failed without a space");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_mask == NAME_ALL && !r_err_latched && !r_out_valid))
        else $error("state not cleared by reset");

endmodule

// File: hw/rtl/datetime_text_validator_core.sv
// Date/time text validator.
//
// Characters of one date/time string arrive on the slave stream, one beat per
// character, with s_tlast high on the final character. On that final beat the
// block produces one beat on the master stream whose low nibble is the status
// (zero means the string is valid); other characters produce nothing.
// format_mode (index 0) selects the format; current_year (index 1) gives the year
// for the February check in month-day formats. The user writes both through
// i_cfg_wr_en, i_cfg_addr and i_cfg_wdata only while the block idles; the block
// itself does not enforce this.
//
// Throughput is one character per cycle while s_tready is high. Each character
// enters the two-entry input queue and is checked from its head; the status of a
// last character is registered in the output register that drives m_tvalid. The
// queue lets the input keep flowing while a status waits there. When m_tready
// stays low with a status held, further characters still pass until the next
// last character, which waits in the queue; once it is full, s_tready drops.
// Reset empties the queue, drops m_tvalid, clears the per-string state and
// loads format_mode 0 (HH:MM:SS) and current_year 2000.
module datetime_text_validator_core #(
    parameter int COUNT_WIDTH = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [13:0] i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic        s_tlast,    // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [3:0] status, [7:4] zero
);
    import dtv_pkg::*;

    // Only the two low year bits matter: the leap rule is divisibility by four.
    logic [2:0] r_mode;
    logic [1:0] r_year_lo;
    t_cfg       cfg;
    logic       q_valid;
    t_item      q_item;
    logic       q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_HMS;
            r_year_lo <= 2'b00;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_FORMAT_MODE:  r_mode    <= i_cfg_wdata[2:0];
                CFG_CURRENT_YEAR: r_year_lo <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign cfg.mode    = r_mode;
    assign cfg.year_lo = r_year_lo;

    dtv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    dtv_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: bench/datetime_text_validator_core_test.sv
module datetime_text_validator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dtv_pkg::*;

    // Width of the position counters inside the block. Segment lengths stick at
    // the all-ones value, and that value never counts as a correct length.
    localparam int COUNT_BITS = 5;
    // Characters that close no string still have to clear the pipeline
    // before a register may change.
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_CHARS = 300;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] DASH_CHAR = 8'h2D;
    localparam logic [7:0] ZERO_CHAR = 8'h30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_addr = CFG_FORMAT_MODE;
    logic [13:0] i_cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] char_code
    logic        s_tlast = 1'b0;  // last_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [3:0] status, [7:4] zero

    datetime_text_validator_core #(
        .COUNT_WIDTH(COUNT_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the validator. The registers as last written, plus the
    // per-string state that is cleared after every last character.
    // ------------------------------------------------------------------
    logic [2:0]            fmt_mode;
    logic [13:0]           cal_year;
    logic [COUNT_BITS-1:0] seg_pos;
    bit                    space_hit;
    bit                    head_bad;
    bit                    err_held;
    logic [3:0]            err_code;
    logic [3:0]            tens_val;
    logic [3:0]            month_val;
    bit                    leap_flag;
    logic [13:0]           name_mask;

    // Status codes still owed by the block, oldest first.
    logic [3:0] status_due[$];
    // Characters of the string being built for the next send.
    logic [7:0] draft[$];

    int unsigned chars_sent;
    int unsigned strings_sent;
    int unsigned statuses_seen;
    int unsigned settings_used;
    int unsigned mismatches;
    int unsigned cycle_count;

    // Idle shaping: the sender groups beats into bursts, the receiver walks a
    // 16-bit ready pattern. A calm phase turns both off.
    int unsigned burst_left;
    bit          calm;
    logic [15:0] ready_pat = 16'hFFFF;
    logic [3:0]  stall_phase = '0;

    function automatic void clear_string();
        seg_pos = '0;
        space_hit = 1'b0;
        head_bad = 1'b0;
        err_held = 1'b0;
        err_code = ST_OK;
        tens_val = '0;
        month_val = '0;
        leap_flag = 1'b0;
        name_mask = '1;
    endfunction

    function automatic string name_text(int unsigned idx);
        case (idx)
            0: return "Mon";
            1: return "Monday";
            2: return "Tue";
            3: return "Tuesday";
            4: return "Wed";
            5: return "Wednesday";
            6: return "Thu";
            7: return "Thursday";
            8: return "Fri";
            9: return "Friday";
            10: return "Sat";
            11: return "Saturday";
            12: return "Sun";
            default: return "Sunday";
        endcase
    endfunction

    function automatic int unsigned days_in(logic [3:0] month);
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            4'd2: return 28;
            default: return 0;
        endcase
    endfunction

    // Only the first error of a segment is kept.
    function automatic void note_error(logic [3:0] code);
        if (!err_held) begin
            err_code = code;
            err_held = 1'b1;
        end
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Two-character number: the tens digit is stored, and the value is ready
    // once the units digit has arrived.
    function automatic bit digit_pair(logic [7:0] c, bit tens, output int unsigned val);
        val = 0;
        if (!is_num(c)) begin
            note_error(ST_DIGIT);
            return 1'b0;
        end
        if (tens) begin
            tens_val = c[3:0];
            return 1'b0;
        end
        val = int'(tens_val) * 10 + int'(c[3:0]);
        return 1'b1;
    endfunction

    function automatic void judge_day(int unsigned day, bit leap);
        int unsigned limit;
        limit = days_in(month_val);
        if (limit == 0) begin
            note_error(ST_INVALID);
            return;
        end
        if (month_val == 4'd2 && leap) limit = 29;
        if (day < 1 || day > limit) note_error(ST_DAY);
    endfunction

    function automatic void month_char(logic [7:0] c, bit tens);
        int unsigned v;
        if (digit_pair(c, tens, v)) begin
            if (v < 1 || v > 12) note_error(ST_MONTH);
            else month_val = v[3:0];
        end
    endfunction

    function automatic void clock_char(int unsigned p, logic [7:0] c);
        int unsigned v;
        bit ready;
        case (p)
            0, 1: begin
                ready = digit_pair(c, p == 0, v);
                if (ready && v > 24) note_error(ST_HOURS);
            end
            2, 5: if (c != COLON_CHAR) note_error(ST_COLON);
            3, 4: begin
                ready = digit_pair(c, p == 3, v);
                if (ready && v > 59) note_error(ST_MINUTES);
            end
            6, 7: begin
                ready = digit_pair(c, p == 6, v);
                if (ready && v > 59) note_error(ST_SECONDS);
            end
            default: ;
        endcase
    endfunction

    function automatic void month_day_char(int unsigned p, logic [7:0] c);
        int unsigned v;
        case (p)
            0, 1: month_char(c, p == 0);
            2: if (c != DASH_CHAR) note_error(ST_DASH);
            // The day tens digit is limited to 0..3 here.
            3: begin
                if (c < "0" || c > "3") note_error(ST_DIGIT);
                else tens_val = c[3:0];
            end
            4: if (digit_pair(c, 1'b0, v)) judge_day(v, cal_year % 4 == 0);
            default: ;
        endcase
    endfunction

    function automatic void date_char(int unsigned p, logic [7:0] c);
        int unsigned v;
        case (p)
            0, 1: if (!is_num(c)) note_error(ST_DIGIT);
            2, 3: if (digit_pair(c, p == 2, v)) leap_flag = (v % 4 == 0);
            4, 7: if (c != DASH_CHAR) note_error(ST_DASH);
            5, 6: month_char(c, p == 5);
            8, 9: if (digit_pair(c, p == 8, v)) judge_day(v, leap_flag);
            default: ;
        endcase
    endfunction

    function automatic void weekday_char(int unsigned p, logic [7:0] c);
        string name;
        for (int i = 0; i < 14; i++) begin
            name = name_text(i);
            if (name_mask[i] && (p >= name.len() || name[p] != c)) name_mask[i] = 1'b0;
        end
    endfunction

    function automatic t_kind segment_kind(logic [2:0] mode, bit tail);
        case (mode)
            MODE_HMS: return KIND_HMS;
            MODE_MMDD: return KIND_MMDD;
            MODE_YMD: return KIND_YMD;
            MODE_WDAY: return KIND_WDAY;
            MODE_WDAY_HMS: return tail ? KIND_HMS : KIND_WDAY;
            default: return tail ? KIND_HMS : KIND_MMDD;
        endcase
    endfunction

    // Verdict on a finished segment: a wrong length beats any position error.
    function automatic logic [3:0] segment_status(t_kind kind, int unsigned len);
        string name;
        if (kind == KIND_WDAY) begin
            for (int i = 0; i < 14; i++) begin
                name = name_text(i);
                if (name_mask[i] && name.len() == len) return ST_OK;
            end
            return ST_WEEKDAY;
        end
        if (kind == KIND_HMS && len != 8) return ST_HMS_LEN;
        if (kind == KIND_MMDD && len != 5) return ST_MMDD_LEN;
        if (kind == KIND_YMD && len != 10) return ST_YMD_LEN;
        return err_code;
    endfunction

    // Advances the mirror by one character. Returns 1 with the status when
    // the character closes a string.
    function automatic bit predict_status(logic [7:0] c, bit is_last, output logic [3:0] st);
        bit    compound;
        t_kind kind;
        logic [3:0] head_st;
        st = ST_OK;
        compound = (fmt_mode == MODE_WDAY_HMS || fmt_mode == MODE_MMDD_HMS);
        if (fmt_mode <= MODE_MMDD_HMS) begin
            if (compound && !space_hit && c == SPACE_CHAR) begin
                // The first space closes the head; its verdict becomes the
                // string's error if it failed.
                head_st = segment_status(segment_kind(fmt_mode, 1'b0), seg_pos);
                space_hit = 1'b1;
                seg_pos = '0;
                head_bad = (head_st != ST_OK);
                err_code = head_st;
                err_held = head_bad;
            end else if (!(compound && head_bad)) begin
                kind = segment_kind(fmt_mode, compound && space_hit);
                if (kind == KIND_WDAY) weekday_char(seg_pos, c);
                else if (!err_held) begin
                    case (kind)
                        KIND_HMS: clock_char(seg_pos, c);
                        KIND_MMDD: month_day_char(seg_pos, c);
                        default: date_char(seg_pos, c);
                    endcase
                end
                if (seg_pos != '1) seg_pos = seg_pos + 1'b1;
            end
        end
        if (!is_last) return 1'b0;
        if (fmt_mode > MODE_MMDD_HMS) st = ST_INVALID;
        else if (compound && !space_hit) st = ST_SPACE;
        else if (compound && head_bad) st = err_code;
        else st = segment_status(segment_kind(fmt_mode, compound), seg_pos);
        clear_string();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result side: the receiver stalls by its pattern and every status beat
    // is matched against the oldest expected code.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            statuses_seen++;
            if (status_due.size() == 0) begin
                $error("status beat 0x%0h with nothing expected", m_tdata);
                mismatches++;
            end else begin
                logic [3:0] want;
                want = status_due.pop_front();
                if (m_tdata[3:0] != want) begin
                    $error("status: expected %0d, got %0d", want, m_tdata[3:0]);
                    mismatches++;
                end
                if (m_tdata[7:4] != 4'h0) begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[7:4]);
                    mismatches++;
                end
            end
        end
        m_tready <= calm || ready_pat[stall_phase];
        stall_phase <= stall_phase + 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d statuses owed",
                     cycle_count, status_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Sends one character beat and updates the mirror once it is taken. The
    // valid stays high after the beat so that back-to-back beats need no
    // second assignment in the same step.
    task automatic send_char(input logic [7:0] c, input bit is_last);
        int unsigned gap;
        logic [3:0] st;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tdata <= c;
        s_tlast <= is_last;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        chars_sent++;
        if (predict_status(c, is_last, st)) begin
            status_due.push_back(st);
            strings_sent++;
        end
    endtask

    task automatic send_draft(input bit finish);
        for (int i = 0; i < draft.size(); i++) begin
            send_char(draft[i], finish && i == draft.size() - 1);
        end
        draft.delete();
    endtask

    function automatic void draft_text(string s);
        for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endfunction

    task automatic send_string(input string s);
        draft.delete();
        draft_text(s);
        send_draft(1'b1);
    endtask

    function automatic void draft_num(int unsigned value, int digits);
        int unsigned scale;
        scale = 1;
        for (int i = 1; i < digits; i++) scale = scale * 10;
        for (int i = 0; i < digits; i++) begin
            draft.push_back(ZERO_CHAR + 8'((value / scale) % 10));
            scale = scale / 10;
        end
    endfunction

    // Well-formed layouts with random content; the values wander out of range
    // now and then so that every range check gets hit.
    function automatic void draft_clock();
        draft_num(($urandom_range(0, 7) != 0) ? $urandom_range(0, 24) : $urandom_range(25, 99), 2);
        draft.push_back(COLON_CHAR);
        draft_num(($urandom_range(0, 7) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99), 2);
        draft.push_back(COLON_CHAR);
        draft_num(($urandom_range(0, 7) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99), 2);
    endfunction

    function automatic void draft_month_day();
        int unsigned month;
        int unsigned day;
        month = ($urandom_range(0, 7) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 19);
        day = ($urandom_range(0, 7) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 39);
        // February around its last day exercises the leap rule.
        if ($urandom_range(0, 3) == 0) begin
            month = 2;
            day = $urandom_range(28, 30);
        end
        draft_num(month, 2);
        draft.push_back(DASH_CHAR);
        draft_num(day, 2);
    endfunction

    function automatic void draft_for_mode(logic [2:0] mode);
        case (mode)
            MODE_HMS: draft_clock();
            MODE_MMDD: draft_month_day();
            MODE_YMD: begin
                draft_num($urandom_range(0, 9999), 4);
                draft.push_back(DASH_CHAR);
                draft_month_day();
            end
            MODE_WDAY: draft_text(name_text($urandom_range(0, 13)));
            MODE_WDAY_HMS: begin
                draft_text(name_text($urandom_range(0, 13)));
                draft.push_back(SPACE_CHAR);
                draft_clock();
            end
            MODE_MMDD_HMS: begin
                draft_month_day();
                draft.push_back(SPACE_CHAR);
                draft_clock();
            end
            default: repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // One random corruption of the draft: a foreign byte, a near character,
    // a lost or extra character, a cut, a long tail, or a case flip.
    function automatic void mangle_draft();
        int unsigned at;
        at = $urandom_range(0, draft.size() - 1);
        case ($urandom_range(0, 6))
            0: draft[at] = 8'($urandom_range(0, 255));
            1: draft[at] = 8'($urandom_range(8'h2D, 8'h3A));
            2: begin
                draft.delete(at);
                if (draft.size() == 0) draft.push_back(ZERO_CHAR);
            end
            3: draft.insert(at, 8'($urandom_range(8'h20, 8'h7E)));
            4: while (draft.size() > at + 1) void'(draft.pop_back());
            5: repeat ($urandom_range(25, 40)) draft.push_back(8'($urandom_range(0, 255)));
            default: draft[at] = draft[at] ^ 8'h20;
        endcase
    endfunction

    task automatic send_random_strings(input int unsigned count);
        repeat (count) begin
            draft.delete();
            draft_for_mode(fmt_mode);
            if ($urandom_range(0, 9) < 3) begin
                repeat ($urandom_range(1, 2)) mangle_draft();
            end
            send_draft(1'b1);
        end
    endtask

    // The sender stops and waits until every owed status has come back, then
    // lets the pipeline clear of characters that close no string.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers, the format mode first and then the year.
    task automatic set_config(input logic [2:0] mode, input logic [13:0] year);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= CFG_FORMAT_MODE;
        i_cfg_wdata <= 14'(mode);
        @(posedge i_clk);
        fmt_mode = mode;
        i_cfg_addr <= CFG_CURRENT_YEAR;
        i_cfg_wdata <= year;
        @(posedge i_clk);
        cal_year = year;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Each phase drains, writes new settings and picks new idle behavior:
    // a steady receiver, a random pattern, or a pattern with a single ready bit.
    task automatic start_phase(input logic [2:0] mode, input logic [13:0] year);
        drain_results();
        set_config(mode, year);
        settings_used++;
        calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
            0: ready_pat = 16'hFFFF;
            1: ready_pat = 16'($urandom) | 16'h0001;
            default: ready_pat = 16'h0001;
        endcase
    endtask

    function automatic logic [2:0] random_mode();
        if ($urandom_range(0, 9) == 0) return 3'($urandom_range(6, 7));
        return 3'($urandom_range(0, 5));
    endfunction

    function automatic logic [13:0] random_year();
        case ($urandom_range(0, 3))
            0: return 14'd0;
            1: return 14'd9999;
            default: return 14'($urandom_range(0, 9999));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hour 24 is legal; the hour and minute fields and the colons are made to fail,
    // and a single character is a string of its own.
    task automatic test_clock_format();
        start_phase(MODE_HMS, 14'd2000);
        send_string("24:00:00");
        send_string("25:59:59");
        send_string("23:60:00");
        send_string("12-34-56");
        send_string("7");
        send_random_strings(8);
    endtask

    // The leap rule comes from the year register here, so the same February
    // day is sent under years of both kinds, the extremes among them.
    task automatic test_month_day_format();
        start_phase(MODE_MMDD, 14'd2000);
        send_string("02-29");
        send_string("13-01");
        send_string("01-40");
        start_phase(MODE_MMDD, 14'd2001);
        send_string("02-29");
        start_phase(MODE_MMDD, 14'd0);
        send_string("02-29");
        send_random_strings(6);
        start_phase(MODE_MMDD, 14'd9999);
        send_string("02-29");
        send_random_strings(8);
    endtask

    task automatic test_full_date_format();
        start_phase(MODE_YMD, random_year());
        send_string("2024-02-29");
        send_string("2023-02-29");
        send_string("1999/12/31");
        send_random_strings(8);
    endtask

    task automatic test_weekday_names();
        start_phase(MODE_WDAY, random_year());
        send_string("Wednesday");
        send_string("wednesday");
        send_string("Monda");
        send_random_strings(8);
    endtask

    // The first space splits head from tail; a second space is an ordinary
    // tail character, and no space at all overrides every other error.
    task automatic test_weekday_with_clock();
        start_phase(MODE_WDAY_HMS, random_year());
        send_string("Sun 24:00:00");
        send_string("Sun12:00:00");
        send_string("Fri  12:00:00");
        send_random_strings(8);
    endtask

    task automatic test_month_day_with_clock();
        start_phase(MODE_MMDD_HMS, 14'd2024);
        send_string("12-25 08:30:00");
        send_random_strings(8);
    endtask

    // Codes 6 and 7 select no format; the extreme bytes ride along here.
    task automatic test_unused_modes();
        start_phase(3'd6, 14'd2000);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_random_strings(3);
        start_phase(3'd7, 14'd2000);
        send_random_strings(3);
    endtask

    // Every character is judged under the format in force when it arrives.
    // A clock prefix followed by a day check leaves no month stored.
    task automatic test_mode_switch_mid_string();
        start_phase(MODE_HMS, 14'd2000);
        draft_text("12:");
        send_draft(1'b0);
        start_phase(MODE_MMDD, 14'd2000);
        send_string("15");
    endtask

    // Strings well past the counter range saturate the position counters.
    task automatic test_overlong_strings();
        start_phase(MODE_HMS, 14'd2000);
        repeat (40) send_char(ZERO_CHAR, 1'b0);
        send_char(ZERO_CHAR, 1'b1);
        start_phase(MODE_WDAY_HMS, 14'd2000);
        repeat (34) send_char("M", 1'b0);
        send_string(" 10:10:10");
        start_phase(MODE_MMDD_HMS, 14'd2000);
        draft_text("01-01 ");
        repeat (36) draft.push_back(COLON_CHAR);
        send_draft(1'b1);
    endtask

    // Bulk of the run: random settings, random strings, and now and then a
    // string whose format changes partway through.
    task automatic test_mixed_random();
        int unsigned stop_at;
        stop_at = chars_sent + RANDOM_CHARS;
        while (chars_sent < stop_at) begin
            start_phase(random_mode(), random_year());
            repeat ($urandom_range(4, 14)) begin
                if ($urandom_range(0, 15) == 0) begin
                    draft.delete();
                    draft_for_mode(fmt_mode);
                    send_draft(1'b0);
                    start_phase(random_mode(), cal_year);
                end
                send_random_strings(1);
            end
        end
    endtask

    initial begin
        fmt_mode = MODE_HMS;
        cal_year = 14'd2000;
        clear_string();
        burst_left = 0;
        calm = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_clock_format();
        test_month_day_format();
        test_full_date_format();
        test_weekday_names();
        test_weekday_with_clock();
        test_month_day_with_clock();
        test_unused_modes();
        test_mode_switch_mid_string();
        test_overlong_strings();
        test_mixed_random();

        drain_results();
        $display("Covered %0d characters in %0d strings over %0d register settings,",
                 chars_sent, strings_sent, settings_used);
        $display("all six formats and both unused codes; %0d status beats checked.",
                 statuses_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dtv_pkg.sv
hw/rtl/dtv_front.sv
hw/rtl/dtv_back.sv
hw/rtl/datetime_text_validator_core.sv
bench/datetime_text_validator_core_test.sv
